// ----- design/ffpa_pkg.sv -----
// Shared types and constants for the first-fit pool allocator.
package ffpa_pkg;

  // Pool geometry
  localparam int POOL_BYTES = 32;
  localparam int PTR_W      = $clog2(POOL_BYTES);
  // Walk position: largest is a header near the end plus a 255-byte skip
  localparam int POS_W      = $clog2(POOL_BYTES + 257);
  localparam int SIZE_W     = 8;
  localparam int OFF_W      = 6;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_BIG   = 2'd1,
    ST_NO_ROOM   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_SKIP
  } state_t;

endpackage

// ----- design/first_fit_pool_allocator.sv -----
// First-fit pool allocator: top level with walk sequencer, start marks and size RAM.
// One request word is taken at a time; in_stall stays high from acceptance until
// the walk ends. The walk starts at position 0 and visits each free position in
// the walk state; at each block header it reads the block size from the size RAM
// in the walk state, then skips past the block in the skip state. The window check
// for an allocation is a single shift-and-mask over the start marks, done in the
// same cycle as the position visit. The result sits in an output register, so the
// next word is accepted while a finished result still waits to be taken.
module first_fit_pool_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       req_type,
  input  logic [ffpa_pkg::SIZE_W-1:0] alloc_size,
  input  logic [ffpa_pkg::OFF_W-1:0]  free_offset,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       granted,
  output logic [ffpa_pkg::OFF_W-1:0]  data_offset,
  output logic [1:0]                 status
);

  import ffpa_pkg::*;

  state_t state, state_next;

  // Latched request
  logic              req_kind;
  logic [SIZE_W-1:0] req_size;
  logic [OFF_W-1:0]  req_off;

  // Walk position and start marks
  logic [POS_W-1:0]      pos, pos_next;
  logic [POOL_BYTES-1:0] marks, marks_next;

  // Size RAM
  logic              ram_we;
  logic [SIZE_W-1:0] ram_rdata;

  // Finish controls
  logic             finish;
  logic             slot_free;
  logic             fin_granted;
  status_t          fin_status;
  logic [OFF_W-1:0] fin_offset;

  logic                  at_end;
  logic                  cur_mark;
  logic [POS_W-1:0]      pos_inc;
  logic [POS_W-1:0]      win_end;
  logic [POOL_BYTES-1:0] win_mask;
  logic [POOL_BYTES-1:0] shifted;
  logic                  win_clear;

  ffpa_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (POOL_BYTES)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos[PTR_W-1:0]),
    .wdata (req_size),
    .raddr (pos[PTR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  // Window check: positions pos..pos+size inside the pool and unmarked
  assign at_end   = (pos >= POS_W'(POOL_BYTES));
  assign cur_mark = marks[pos[PTR_W-1:0]];
  assign pos_inc  = pos + POS_W'(1);
  assign win_end  = pos + POS_W'(req_size);
  assign shifted  = marks >> pos[PTR_W-1:0];

  always_comb begin
    for (int i = 0; i < POOL_BYTES; i++) begin
      win_mask[i] = (POS_W'(i) <= POS_W'(req_size));
    end
  end

  assign win_clear = (win_end < POS_W'(POOL_BYTES)) && !(|(shifted & win_mask));

  // Sequencer
  always_comb begin
    state_next  = state;
    pos_next    = pos;
    marks_next  = marks;
    ram_we      = 1'b0;
    finish      = 1'b0;
    fin_granted = 1'b0;
    fin_status  = ST_OK;
    fin_offset  = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_WALK;
          pos_next   = '0;
        end
      end

      S_WALK: begin
        if (at_end) begin
          finish     = 1'b1;
          fin_status = (req_kind == REQ_ALLOC) ? ST_NO_ROOM : ST_NOT_FOUND;
        end else if (cur_mark) begin
          if (req_kind == REQ_FREE && pos_inc == POS_W'(req_off)) begin
            finish      = 1'b1;
            fin_granted = 1'b1;
            if (slot_free) begin
              marks_next[pos[PTR_W-1:0]] = 1'b0;
            end
          end else begin
            // size read issued this cycle, skip next cycle
            state_next = S_SKIP;
          end
        end else if (req_kind == REQ_ALLOC && win_clear) begin
          finish      = 1'b1;
          fin_granted = 1'b1;
          fin_offset  = pos_inc[OFF_W-1:0];
          if (slot_free) begin
            marks_next[pos[PTR_W-1:0]] = 1'b1;
            ram_we                     = 1'b1;
          end
        end else begin
          pos_next = pos_inc;
        end

        if (finish && slot_free) begin
          state_next = S_IDLE;
        end
      end

      S_SKIP: begin
        pos_next   = pos_inc + POS_W'(ram_rdata);
        state_next = S_WALK;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      marks     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      marks <= marks_next;
      if (finish && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (state == S_IDLE && in_valid) begin
      req_kind <= req_type;
      req_size <= alloc_size;
      req_off  <= free_offset;
    end
    if (finish && slot_free) begin
      granted     <= fin_granted;
      data_offset <= fin_offset;
      status      <= fin_status;
    end
  end

`ifndef SYNTHESIS
  // A new result only comes out of the walk
  a_result_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_WALK)
    else $error("result appeared outside the walk");

  // A size skip always follows a header visit
  a_skip_after_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_SKIP |-> $past(state) == S_WALK)
    else $error("skip state entered without a header read");

  // A granted allocation adds exactly one start mark
  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    (finish && slot_free && fin_granted && req_kind == REQ_ALLOC)
      |=> $countones(marks) == $past($countones(marks)) + 1)
    else $error("granted allocation did not add one mark");

  // A granted free removes exactly one start mark
  a_free_marks: assert property (@(posedge clk) disable iff (rst)
    (finish && slot_free && fin_granted && req_kind == REQ_FREE)
      |=> $countones(marks) + 1 == $past($countones(marks)))
    else $error("granted free did not remove one mark");

  // Refused results carry no grant and no offset
  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_NO_ROOM || status == ST_NOT_FOUND))
      |-> (!granted && data_offset == '0))
    else $error("refused result carries a grant or offset");
`endif

endmodule

// ----- design/ffpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the first-fit pool allocator: pool predictor, scoreboard and drivers.
module tb_top;
  import ffpa_pkg::*;

  // Expected result word
  typedef struct packed {
    logic            granted;
    logic [OFF_W-1:0] data_offset;
    status_t         status;
  } grant_word_t;

  // Tracks the pool layout and the result words still owed by the block
  class pool_tracker;
    bit              marks[POOL_BYTES];
    bit [SIZE_W-1:0] sizes[POOL_BYTES];
    grant_word_t     owed_results[$];
    int              fails;
    int              seen;

    function new();
      fails = 0;
      seen  = 0;
      foreach (marks[i]) begin
        marks[i] = 0;
        sizes[i] = '0;
      end
    endfunction

    task report(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want, seen);
      fails++;
    endtask

    // True when positions p..p+sz are inside the pool and carry no header
    function bit window_free(int p, int sz);
      if (p + sz >= POOL_BYTES) return 0;
      for (int k = p; k <= p + sz; k++) begin
        if (marks[k]) return 0;
      end
      return 1;
    endfunction

    // First-fit walk for an allocation
    function grant_word_t place_block(int sz);
      grant_word_t w;
      int p;
      w = '{granted: 1'b0, data_offset: '0, status: ST_NO_ROOM};
      p = 0;
      while (p < POOL_BYTES) begin
        if (marks[p]) begin
          p += int'(sizes[p]) + 1;
        end else if (window_free(p, sz)) begin
          marks[p] = 1;
          sizes[p] = sz[SIZE_W-1:0];
          w.granted = 1'b1;
          w.data_offset = OFF_W'(p + 1);
          w.status = ST_OK;
          return w;
        end else begin
          p += 1;
        end
      end
      return w;
    endfunction

    // Same walk, looking for the header whose data starts at off
    function grant_word_t release_block(int off);
      grant_word_t w;
      int p;
      w = '{granted: 1'b0, data_offset: '0, status: ST_NOT_FOUND};
      p = 0;
      while (p < POOL_BYTES) begin
        if (marks[p]) begin
          if (p + 1 == off) begin
            marks[p] = 0;
            sizes[p] = '0;
            w.granted = 1'b1;
            w.status = ST_OK;
            return w;
          end
          p += int'(sizes[p]) + 1;
        end else begin
          p += 1;
        end
      end
      return w;
    endfunction

    function void note_request(logic kind, logic [SIZE_W-1:0] sz, logic [OFF_W-1:0] off);
      if (kind == REQ_ALLOC) owed_results.push_back(place_block(int'(sz)));
      else owed_results.push_back(release_block(int'(off)));
    endfunction

    task check_word(logic g, logic [OFF_W-1:0] off, logic [1:0] st);
      grant_word_t w;
      seen++;
      if (owed_results.size() == 0) begin
        report("unexpected word", int'(st), -1);
        return;
      end
      w = owed_results.pop_front();
      if (g !== w.granted) report("granted", int'(g), int'(w.granted));
      if (off !== w.data_offset) report("data_offset", int'(off), int'(w.data_offset));
      if (st !== w.status) report("status", int'(st), int'(w.status));
    endtask

    function int pending();
      return owed_results.size();
    endfunction

    function int live_blocks();
      int n;
      n = 0;
      foreach (marks[i]) if (marks[i]) n++;
      return n;
    endfunction

    // Data offset of a random live block, 0 if the pool is empty
    function logic [OFF_W-1:0] any_live_offset();
      int hdrs[$];
      foreach (marks[i]) if (marks[i]) hdrs.push_back(i);
      if (hdrs.size() == 0) return '0;
      return OFF_W'(hdrs[$urandom_range(0, hdrs.size() - 1)] + 1);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              req_type;
  logic [SIZE_W-1:0] alloc_size;
  logic [OFF_W-1:0]  free_offset;
  logic              out_valid;
  logic              out_stall;
  logic              granted;
  logic [OFF_W-1:0]  data_offset;
  logic [1:0]        status;

  pool_tracker pool = new();
  bit calm = 0;
  int send_gap_pct = 25;

  first_fit_pool_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .alloc_size(alloc_size), .free_offset(free_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .granted(granted), .data_offset(data_offset), .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one request word and hold it until the block takes it
  task automatic send_word(logic kind, logic [SIZE_W-1:0] sz, logic [OFF_W-1:0] off);
    if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    alloc_size  <= sz;
    free_offset <= off;
    do @(posedge clk); while (in_stall);
    pool.note_request(kind, sz, off);
  endtask

  task automatic alloc_word(int sz);
    send_word(REQ_ALLOC, SIZE_W'(sz), OFF_W'($urandom_range(0, 32)));
  endtask

  task automatic free_word(int off);
    send_word(REQ_FREE, SIZE_W'($urandom_range(0, 255)), OFF_W'(off));
  endtask

  // Mostly alloc/free of live blocks; some oversize and stray offsets
  task automatic random_word();
    int n, r, sz;
    n = pool.live_blocks();
    r = $urandom_range(0, 99);
    if (n == 0 || r < (n < 4 ? 70 : (n < 10 ? 50 : 35))) begin
      r = $urandom_range(0, 99);
      if (r < 60) sz = $urandom_range(0, 3);
      else if (r < 85) sz = $urandom_range(4, 15);
      else if (r < 95) sz = $urandom_range(16, 31);
      else sz = $urandom_range(32, 255);
      alloc_word(sz);
    end else if ($urandom_range(0, 99) < 80) begin
      free_word(int'(pool.any_live_offset()));
    end else begin
      free_word($urandom_range(0, 32));
    end
  endtask

  // Stimulus
  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    req_type    <= REQ_ALLOC;
    alloc_size  <= '0;
    free_offset <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, full pool, last position, stray offsets, holes
    alloc_word(0);
    alloc_word(255);
    free_word(1);
    alloc_word(31);
    alloc_word(0);
    free_word(0);
    free_word(32);
    free_word(2);
    free_word(1);
    alloc_word(30);
    alloc_word(0);
    alloc_word(0);
    free_word(32);
    free_word(32);
    free_word(1);
    alloc_word(3);
    alloc_word(5);
    alloc_word(2);
    free_word(5);
    alloc_word(6);
    alloc_word(4);
    free_word(11);
    free_word(1);
    free_word(5);
    free_word(14);

    for (int i = 0; i < 680; i++) begin
      if (i % 50 == 0) send_gap_pct = 25 * $urandom_range(0, 2);
      if (i == 600) calm = 1;
      random_word();
    end
    in_valid <= 1'b0;

    while (pool.pending() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (pool.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: random stall bursts and one long hold-off
  initial begin
    int stall_left, stall_pct;
    bit held;
    stall_left = 0;
    stall_pct  = 20;
    held       = 0;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        pool.check_word(granted, data_offset, status);
        if (pool.seen % 50 == 0) stall_pct = 20 * $urandom_range(0, 2);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!held && pool.seen >= 150) begin
        held = 1;
        stall_left = 400;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 8);
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Hang guard
  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
design/ffpa_pkg.sv
design/ffpa_ram.sv
design/first_fit_pool_allocator.sv
sim/tb_top.sv
